// File: hw/rtl/ue8_pkg.sv
// ============================================================================
// ue8_pkg: shared types and constants of the unicode escape decoder
// Item and result structs, the escape phase type, the run record that
// travels from the front end to the back end, and the UTF-8 constants.
// ============================================================================
package ue8_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned RUN_BYTES   = 6;

	localparam logic [7:0] BACKSLASH  = 8'h5C;
	localparam logic [7:0] LETTER_U   = 8'h75;
	localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF8_CONT  = 8'h80;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       string_end;
	} out_item_t;

	// Escape progress: a backslash held, then backslash and 'u' with 0..3 digits.
	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_BSL  = 3'd1,
		PH_HEX0 = 3'd2,
		PH_HEX1 = 3'd3,
		PH_HEX2 = 3'd4,
		PH_HEX3 = 3'd5
	} phase_t;

	// All output bytes caused by one input item.
	typedef struct packed {
		logic [RUN_BYTES-1:0][7:0] bytes;
		logic [2:0]                cnt;
		logic                      last;
	} run_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// File: hw/rtl/ue8_front.sv
// ============================================================================
// ue8_front: escape tracker
// Accepts one input byte per transfer, tracks the escape in progress and
// builds the run of output bytes that the byte causes.
// ============================================================================
module ue8_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  ue8_pkg::in_item_t  item,
	input  ue8_pkg::q_stat_t   q_stat,
	output logic               push,
	output ue8_pkg::run_t      push_run
);

	ue8_pkg::phase_t phase_q, phase_nxt;
	logic [7:0]      digit_q [3];
	logic [11:0]     code_q;

	logic        acc;
	logic [7:0]  b;
	logic        last;
	logic        is_bs;
	logic        is_u;
	logic        tail;
	logic        hex_ok;
	logic [3:0]  hex_val;
	logic [2:0]  ph;
	logic [2:0]  flush_len;
	logic        use_code;
	logic [15:0] code_full;
	logic [ue8_pkg::RUN_BYTES-1:0][7:0] seq;
	logic [ue8_pkg::RUN_BYTES-1:0][7:0] enc;
	logic [2:0]  enc_cnt;

	assign item_stall = q_stat.full;
	assign acc        = item_valid && !q_stat.full;
	assign b          = item.in_byte;
	assign last       = item.in_last;
	assign is_bs      = (b == ue8_pkg::BACKSLASH);
	assign is_u       = (b == ue8_pkg::LETTER_U);
	assign ph         = 3'(phase_q);
	// The byte itself goes out unless it opens a new escape that stays open.
	assign tail       = !is_bs || last;

	always_comb begin
		hex_ok  = 1'b1;
		hex_val = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			hex_val = 4'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			hex_val = 4'(b - 8'h37);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			hex_val = 4'(b - 8'h57);
		end else begin
			hex_ok = 1'b0;
		end
	end

	// Next escape phase.
	always_comb begin
		phase_nxt = ue8_pkg::PH_IDLE;
		case (phase_q)
			ue8_pkg::PH_IDLE: begin
				phase_nxt = (is_bs && !last) ? ue8_pkg::PH_BSL : ue8_pkg::PH_IDLE;
			end
			ue8_pkg::PH_BSL: begin
				if (is_u) phase_nxt = last ? ue8_pkg::PH_IDLE : ue8_pkg::PH_HEX0;
				else phase_nxt = (is_bs && !last) ? ue8_pkg::PH_BSL : ue8_pkg::PH_IDLE;
			end
			ue8_pkg::PH_HEX0: begin
				if (hex_ok) phase_nxt = last ? ue8_pkg::PH_IDLE : ue8_pkg::PH_HEX1;
				else phase_nxt = (is_bs && !last) ? ue8_pkg::PH_BSL : ue8_pkg::PH_IDLE;
			end
			ue8_pkg::PH_HEX1: begin
				if (hex_ok) phase_nxt = last ? ue8_pkg::PH_IDLE : ue8_pkg::PH_HEX2;
				else phase_nxt = (is_bs && !last) ? ue8_pkg::PH_BSL : ue8_pkg::PH_IDLE;
			end
			ue8_pkg::PH_HEX2: begin
				if (hex_ok) phase_nxt = last ? ue8_pkg::PH_IDLE : ue8_pkg::PH_HEX3;
				else phase_nxt = (is_bs && !last) ? ue8_pkg::PH_BSL : ue8_pkg::PH_IDLE;
			end
			ue8_pkg::PH_HEX3: begin
				if (hex_ok) phase_nxt = ue8_pkg::PH_IDLE;
				else phase_nxt = (is_bs && !last) ? ue8_pkg::PH_BSL : ue8_pkg::PH_IDLE;
			end
			default: phase_nxt = ue8_pkg::PH_IDLE;
		endcase
	end

	// Run length. A flushed prefix is the held bytes followed by the current
	// byte at the position of the phase, so only its length varies.
	always_comb begin
		flush_len = 3'd0;
		use_code  = 1'b0;
		case (phase_q)
			ue8_pkg::PH_IDLE: begin
				flush_len = tail ? 3'd1 : 3'd0;
			end
			ue8_pkg::PH_BSL: begin
				if (is_u) flush_len = last ? 3'd2 : 3'd0;
				else flush_len = tail ? 3'd2 : 3'd1;
			end
			ue8_pkg::PH_HEX0, ue8_pkg::PH_HEX1, ue8_pkg::PH_HEX2: begin
				if (hex_ok) flush_len = last ? ph + 3'd1 : 3'd0;
				else flush_len = tail ? ph + 3'd1 : ph;
			end
			ue8_pkg::PH_HEX3: begin
				if (hex_ok) use_code = 1'b1;
				else flush_len = tail ? 3'd6 : 3'd5;
			end
			default: flush_len = 3'd0;
		endcase
	end

	always_comb begin
		seq[0] = ue8_pkg::BACKSLASH;
		seq[1] = ue8_pkg::LETTER_U;
		seq[2] = digit_q[0];
		seq[3] = digit_q[1];
		seq[4] = digit_q[2];
		seq[5] = 8'h00;
		for (int i = 0; i < ue8_pkg::RUN_BYTES; i++) begin
			if (ph == 3'(i)) seq[i] = b;
		end
	end

	assign code_full = {code_q, hex_val};

	always_comb begin
		enc = '0;
		if (code_full[15:7] == 9'd0) begin
			enc[0]  = code_full[7:0];
			enc_cnt = 3'd1;
		end else if (code_full[15:11] == 5'd0) begin
			enc[0]  = ue8_pkg::UTF8_LEAD2 | {3'b000, code_full[10:6]};
			enc[1]  = ue8_pkg::UTF8_CONT | {2'b00, code_full[5:0]};
			enc_cnt = 3'd2;
		end else begin
			enc[0]  = ue8_pkg::UTF8_LEAD3 | {4'b0000, code_full[15:12]};
			enc[1]  = ue8_pkg::UTF8_CONT | {2'b00, code_full[11:6]};
			enc[2]  = ue8_pkg::UTF8_CONT | {2'b00, code_full[5:0]};
			enc_cnt = 3'd3;
		end
	end

	assign push_run.bytes = use_code ? enc : seq;
	assign push_run.cnt   = use_code ? enc_cnt : flush_len;
	assign push_run.last  = last;
	assign push           = acc && (push_run.cnt != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ue8_pkg::PH_IDLE;
			code_q  <= '0;
		end else if (acc) begin
			phase_q <= phase_nxt;
			if (phase_q == ue8_pkg::PH_BSL && is_u) begin
				code_q <= '0;
			end else if (hex_ok && (phase_q == ue8_pkg::PH_HEX0 ||
					phase_q == ue8_pkg::PH_HEX1 || phase_q == ue8_pkg::PH_HEX2)) begin
				code_q <= {code_q[7:0], hex_val};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && hex_ok) begin
			if (phase_q == ue8_pkg::PH_HEX0) digit_q[0] <= b;
			if (phase_q == ue8_pkg::PH_HEX1) digit_q[1] <= b;
			if (phase_q == ue8_pkg::PH_HEX2) digit_q[2] <= b;
		end
	end

	// The end of a string never leaves an escape open.
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last |=> phase_q == ue8_pkg::PH_IDLE)
		else $error("escape still open after last byte");

endmodule

// File: hw/rtl/ue8_queue.sv
// ============================================================================
// ue8_queue: run queue
// Short first-in first-out queue of run records between the escape
// tracker and the byte serializer.
// ============================================================================
module ue8_queue #(
	parameter int unsigned DEPTH = ue8_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ue8_pkg::run_t    push_run,
	input  logic             pop,
	output ue8_pkg::run_t    head,
	output ue8_pkg::q_stat_t q_stat
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	ue8_pkg::run_t  store_q [DEPTH];
	logic [PW-1:0]  wr_q;
	logic [PW-1:0]  rd_q;
	logic [CW-1:0]  cnt_q;

	assign q_stat.full  = (cnt_q == CW'(DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign head         = store_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) store_q[wr_q] <= push_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("run queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("run queue read while empty");

endmodule

// File: hw/rtl/ue8_back.sv
// ============================================================================
// ue8_back: byte serializer
// Sends the bytes of the run at the head of the queue one per transfer
// through a registered output, marking run and string ends.
// ============================================================================
module ue8_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ue8_pkg::run_t      head,
	input  ue8_pkg::q_stat_t   q_stat,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output ue8_pkg::out_item_t result
);

	logic [2:0]         idx_q;
	logic               ov_q;
	ue8_pkg::out_item_t out_q;
	logic               load;
	logic               end_of_run;

	// The output register takes a new byte when it is empty or being drained.
	assign load       = !q_stat.empty && (!ov_q || !result_stall);
	assign end_of_run = (idx_q == head.cnt - 3'd1);
	assign pop        = load && end_of_run;

	assign result_valid = ov_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (!ov_q || !result_stall) ov_q <= !q_stat.empty;
			if (load) idx_q <= end_of_run ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte   <= head.bytes[idx_q];
			out_q.run_last   <= end_of_run;
			out_q.string_end <= end_of_run && head.last;
		end
	end

	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> head.cnt != 3'd0)
		else $error("empty run in queue");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		!q_stat.empty |-> idx_q < head.cnt)
		else $error("byte index beyond run length");

endmodule

// File: hw/rtl/unicode_escape_to_utf8_core.sv
// The first output byte of an item passes through the run queue, then the output register.
// Throughput: one input byte per cycle unless the run queue is full; the serializer sends
// one output byte per cycle while result_stall is low and works through one run at a time.
// The run queue (QUEUE_DEPTH runs) sets how far input can run ahead of the serializer.
// Reset clears the escape state, the run queue and the output valid.
// ============================================================================
// unicode_escape_to_utf8_core: backslash-u escape to UTF-8 decoder
// Escape tracker front end, run queue, and byte serializer back end.
// ============================================================================
module unicode_escape_to_utf8_core #(
	parameter int unsigned QUEUE_DEPTH = ue8_pkg::QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  ue8_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output ue8_pkg::out_item_t result
);

	logic             push;
	logic             pop;
	ue8_pkg::run_t    push_run;
	ue8_pkg::run_t    head;
	ue8_pkg::q_stat_t q_stat;

	ue8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.q_stat     (q_stat),
		.push       (push),
		.push_run   (push_run)
	);

	ue8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	ue8_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_stat       (q_stat),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_top: self-checking bench of the unicode escape to UTF-8 decoder
// A short table of hand-picked bytes, then random escaped strings, are sent
// through the item channel while the result channel stalls at random. A
// local escape decoder predicts all flags and the bytes of untyped rows.
// ============================================================================
module tb_top;

	localparam int N_RANDOM       = 330;
	localparam int CALM_TAIL      = 40;
	localparam int SQUEEZE_AT     = 60;
	localparam int SQUEEZE_CYCLES = 80;
	localparam int DRAIN_LIMIT    = 5000;
	localparam int SETTLE_CYCLES  = 8;

	// One line of the stimulus table. When typed is set, the n bytes e0..e2
	// are the hand-written expectation of that byte.
	typedef struct packed {
		logic [7:0] b;
		logic       l;
		logic       typed;
		logic [2:0] n;
		logic [7:0] e0;
		logic [7:0] e1;
		logic [7:0] e2;
	} text_row_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	ue8_pkg::in_item_t  item;
	logic               result_valid;
	logic               result_stall;
	ue8_pkg::out_item_t result;

	text_row_t          text_plan [$];
	ue8_pkg::out_item_t utf8_due [$];
	int                 errors = 0;
	int                 cyc_count = 0;
	bit                 calm;
	bit                 squeeze_req;
	bit                 squeezing = 1'b0;
	bit                 squeeze_done = 1'b0;

	// Local copy of the escape tracker.
	ue8_pkg::phase_t esc_phase;
	logic [7:0]      esc_digits [4];
	logic [15:0]     esc_code;
	logic [7:0]      run_bytes [ue8_pkg::RUN_BYTES];
	int              run_cnt;

	unicode_escape_to_utf8_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	always @(posedge clk) begin
		cyc_count <= cyc_count + 1;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
		errors++;
	endtask

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return 8'h30 + {4'h0, v};
		if ($urandom_range(0, 1) == 0) return 8'h41 + {4'h0, v} - 8'd10;
		return 8'h61 + {4'h0, v} - 8'd10;
	endfunction

	task automatic add_byte(input logic [7:0] b);
		if (run_cnt < ue8_pkg::RUN_BYTES) begin
			run_bytes[run_cnt] = b;
			run_cnt++;
		end
	endtask

	// Gives back the held prefix as written and drops the escape.
	task automatic flush_held();
		int k;
		if (esc_phase >= ue8_pkg::PH_BSL) add_byte(ue8_pkg::BACKSLASH);
		if (esc_phase >= ue8_pkg::PH_HEX0) begin
			add_byte(ue8_pkg::LETTER_U);
			for (k = 0; k + 2 < int'(esc_phase); k++) add_byte(esc_digits[k]);
		end
		esc_phase = ue8_pkg::PH_IDLE;
	endtask

	task automatic encode_code();
		if (esc_code < 16'h0080) begin
			add_byte(esc_code[7:0]);
		end else if (esc_code < 16'h0800) begin
			add_byte(ue8_pkg::UTF8_LEAD2 | {3'b000, esc_code[10:6]});
			add_byte(ue8_pkg::UTF8_CONT | {2'b00, esc_code[5:0]});
		end else begin
			add_byte(ue8_pkg::UTF8_LEAD3 | {4'h0, esc_code[15:12]});
			add_byte(ue8_pkg::UTF8_CONT | {2'b00, esc_code[11:6]});
			add_byte(ue8_pkg::UTF8_CONT | {2'b00, esc_code[5:0]});
		end
	endtask

	task automatic decode_byte(input logic [7:0] b, input logic last);
		int  h;
		bit  taken;
		run_cnt = 0;
		taken = 0;
		if (esc_phase == ue8_pkg::PH_BSL) begin
			if (b == ue8_pkg::LETTER_U) begin
				esc_phase = ue8_pkg::PH_HEX0;
				esc_code = '0;
				taken = 1;
			end else begin
				flush_held();
			end
		end else if (esc_phase != ue8_pkg::PH_IDLE) begin
			h = hex_nibble(b);
			if (h >= 0) begin
				esc_digits[int'(esc_phase) - 2] = b;
				esc_code = {esc_code[11:0], h[3:0]};
				if (esc_phase == ue8_pkg::PH_HEX3) begin
					encode_code();
					esc_phase = ue8_pkg::PH_IDLE;
				end else begin
					esc_phase = ue8_pkg::phase_t'(esc_phase + 3'd1);
				end
				taken = 1;
			end else begin
				flush_held();
			end
		end
		// The offending byte of a malformed escape is looked at afresh.
		if (!taken) begin
			if (b == ue8_pkg::BACKSLASH) esc_phase = ue8_pkg::PH_BSL;
			else add_byte(b);
		end
		if (last && esc_phase != ue8_pkg::PH_IDLE) flush_held();
	endtask

	task automatic queue_expected(input text_row_t r);
		logic [7:0]         want [ue8_pkg::RUN_BYTES];
		int                 cnt;
		int                 k;
		ue8_pkg::out_item_t o;
		decode_byte(r.b, r.l);
		if (r.typed) begin
			cnt = int'(r.n);
			want[0] = r.e0;
			want[1] = r.e1;
			want[2] = r.e2;
		end else begin
			cnt = run_cnt;
			for (k = 0; k < ue8_pkg::RUN_BYTES; k++) want[k] = run_bytes[k];
		end
		for (k = 0; k < cnt; k++) begin
			o.out_byte = want[k];
			o.run_last = (k == cnt - 1);
			o.string_end = (k == cnt - 1) && r.l;
			utf8_due.push_back(o);
		end
	endtask

	task automatic add_row(input logic [7:0] b, input logic l, input logic typed,
			input logic [2:0] n, input logic [7:0] e0, input logic [7:0] e1,
			input logic [7:0] e2);
		text_row_t r;
		r = {b, l, typed, n, e0, e1, e2};
		text_plan.push_back(r);
	endtask

	// Random strings: mostly well-formed escapes over all three UTF-8 lengths,
	// mixed with plain bytes and escapes that break off or end the string.
	task automatic build_random(input int total);
		logic [7:0]  txt [$];
		logic [15:0] code;
		int          nseg;
		int          seg;
		int          kind;
		int          ndig;
		int          k;
		while (text_plan.size() < total) begin
			txt.delete();
			nseg = $urandom_range(1, 6);
			for (seg = 0; seg < nseg; seg++) begin
				kind = $urandom_range(0, 99);
				if (kind < 55) begin
					case ($urandom_range(0, 3))
						0: code = 16'($urandom_range(16'h0000, 16'h007F));
						1: code = 16'($urandom_range(16'h0080, 16'h07FF));
						2: code = 16'($urandom_range(16'h0800, 16'hFFFF));
						default: code = 16'($urandom_range(16'hD800, 16'hDFFF));
					endcase
					txt.push_back(ue8_pkg::BACKSLASH);
					txt.push_back(ue8_pkg::LETTER_U);
					for (k = 3; k >= 0; k--) txt.push_back(hex_char(code[k*4 +: 4]));
				end else if (kind < 75) begin
					txt.push_back(8'($urandom_range(0, 255)));
				end else if (kind < 85) begin
					txt.push_back(8'($urandom_range(8'h20, 8'h7E)));
				end else begin
					txt.push_back(ue8_pkg::BACKSLASH);
					ndig = $urandom_range(0, 4);
					if (ndig > 0) begin
						txt.push_back(ue8_pkg::LETTER_U);
						for (k = 1; k < ndig; k++)
							txt.push_back(hex_char(4'($urandom_range(0, 15))));
					end
					if ($urandom_range(0, 3) != 0) txt.push_back(8'($urandom_range(0, 255)));
				end
			end
			for (k = 0; k < txt.size(); k++)
				add_row(txt[k], k == txt.size() - 1, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		end
	endtask

	always @(posedge clk) begin : check_out
		ue8_pkg::out_item_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (utf8_due.size() == 0) begin
				report_mismatch("byte with nothing due", int'(result.out_byte), 0);
			end else begin
				want = utf8_due.pop_front();
				if (result.out_byte !== want.out_byte)
					report_mismatch("out_byte", int'(result.out_byte), int'(want.out_byte));
				if (result.run_last !== want.run_last)
					report_mismatch("run_last", int'(result.run_last), int'(want.run_last));
				if (result.string_end !== want.string_end)
					report_mismatch("string_end", int'(result.string_end),
						int'(want.string_end));
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off so that the run
	// queue fills and the input side has to stall.
	initial begin : rx_side
		int hold;
		result_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (squeeze_req && !squeeze_done) begin
				squeezing = 1;
				result_stall <= 1'b1;
				for (hold = 0; hold < SQUEEZE_CYCLES; hold++) @(posedge clk);
				result_stall <= 1'b0;
				squeezing = 0;
				squeeze_done = 1;
			end else if (!calm && (cyc_count / 64) % 3 != 0 && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	initial begin : tx_side
		int        idx;
		int        w;
		int        n_directed;
		text_row_t r;
		calm = 0;
		squeeze_req = 0;
		esc_phase = ue8_pkg::PH_IDLE;
		esc_code = '0;
		for (w = 0; w < 4; w++) esc_digits[w] = 8'h00;
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;

		// Byte extremes, then a plain byte that closes a three-byte string.
		add_row(8'h00, 1'b0, 1'b1, 3'd1, 8'h00, 8'h00, 8'h00);
		add_row(8'hFF, 1'b0, 1'b1, 3'd1, 8'hFF, 8'h00, 8'h00);
		add_row(8'h41, 1'b1, 1'b1, 3'd1, 8'h41, 8'h00, 8'h00);
		// A zero code still yields one byte.
		add_row(ue8_pkg::BACKSLASH, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(ue8_pkg::LETTER_U, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h30, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h30, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h30, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h30, 1'b0, 1'b1, 3'd1, 8'h00, 8'h00, 8'h00);
		// Largest code, three bytes, closing the string.
		add_row(ue8_pkg::BACKSLASH, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(ue8_pkg::LETTER_U, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h46, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h66, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h46, 1'b0, 1'b1, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h66, 1'b1, 1'b1, 3'd3, 8'hEF, 8'hBF, 8'hBF);
		// A lone surrogate, mixed case digits.
		add_row(ue8_pkg::BACKSLASH, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(ue8_pkg::LETTER_U, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h44, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h38, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h33, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h64, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		// A backslash after a backslash, then a bad digit, then a cut-off escape.
		add_row(ue8_pkg::BACKSLASH, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(ue8_pkg::BACKSLASH, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(ue8_pkg::LETTER_U, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h37, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(8'h67, 1'b0, 1'b0, 3'd0, 8'h00, 8'h00, 8'h00);
		add_row(ue8_pkg::BACKSLASH, 1'b1, 1'b1, 3'd1, ue8_pkg::BACKSLASH, 8'h00, 8'h00);
		n_directed = text_plan.size();
		build_random(n_directed + N_RANDOM);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (idx = 0; idx < text_plan.size(); idx++) begin
			r = text_plan[idx];
			calm = (idx >= text_plan.size() - CALM_TAIL);
			if (idx == n_directed + SQUEEZE_AT) squeeze_req = 1;
			if (!calm && !squeezing && (idx / 40) % 3 != 0 && $urandom_range(0, 7) == 0) begin
				item_valid <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			item <= {r.b, r.l};
			item_valid <= 1'b1;
			@(posedge clk);
			while (item_stall) @(posedge clk);
			// The byte transferred at this edge.
			queue_expected(r);
		end
		item_valid <= 1'b0;

		for (w = 0; w < DRAIN_LIMIT && utf8_due.size() != 0; w++) @(posedge clk);
		if (utf8_due.size() != 0) report_mismatch("bytes never delivered", 0, utf8_due.size());
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/ue8_pkg.sv
hw/rtl/ue8_front.sv
hw/rtl/ue8_queue.sv
hw/rtl/ue8_back.sv
hw/rtl/unicode_escape_to_utf8_core.sv
tb/sv/tb_top.sv
